>>> sv/sds_pkg.sv
package sds_pkg;

    // Fixed widths of the item and register fields
    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int PULSE_W   = 12;
    localparam int TICK_W    = 12;
    localparam int PROFILE_W = 24;
    localparam int WINDOW_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int CHAN_W    = 3;
    localparam int LOWRUN_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Profile store and profile limits
    localparam int PROFILE_REGS         = 6;
    localparam int SLOT_COUNT           = 6;
    localparam int REQUIRED_LOW_SAMPLES = 2;
    localparam int PULSE_MIN            = 280;
    localparam int PULSE_MAX            = 325;
    localparam int RUN_MIN_TICKS        = 100;
    localparam int RUN_MAX_TICKS        = 2500;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CAL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAULT = 3'd4;

    // Cycle status codes
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DETECTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CALDONE  = 3'd7;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT6  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READY  = 3'd7;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd20;

    typedef logic [PROFILE_W-1:0] profile_t;
    typedef profile_t [PROFILE_REGS-1:0] profile_arr_t;

    // Profiles after reset: pulse 307, run 2100/2100/2100/1850/2100/1600
    localparam profile_arr_t PROFILE_RESET = {
        24'd6553907, 24'd8601907, 24'd7577907,
        24'd8601907, 24'd8601907, 24'd8601907
    };

    // One result beat
    typedef struct packed {
        logic                accepted;
        logic                busy_res;
        logic                motor_on;
        logic [CHAN_W-1:0]   motor_channel;
        logic [PULSE_W-1:0]  motor_pulse;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   last_slot;
        logic                finished;
    } res_t;

endpackage

>>> sv/sds_core.sv
module sds_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic [sds_pkg::MODE_W-1:0]           mode,
    input  logic [sds_pkg::SLOT_W-1:0]           slot,
    input  logic                                 beam_clear,
    input  sds_pkg::profile_arr_t                profiles,
    input  logic [sds_pkg::WINDOW_W-1:0]         clear_window,
    input  logic                                 drive_ready,
    output sds_pkg::res_t                        res
);
    import sds_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CLEAR = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_CAL   = 2'd3;

    logic [1:0]          phase_reg,    phase_next;
    logic [TICK_W-1:0]   elapsed_reg,  elapsed_next;
    logic [LOWRUN_W-1:0] low_run_reg,  low_run_next;
    logic [CHAN_W-1:0]   channel_reg,  channel_next;
    logic [PULSE_W-1:0]  pulse_reg,    pulse_next;
    logic [TICK_W-1:0]   limit_reg,    limit_next;
    logic [STATUS_W-1:0] status_reg,   status_next;
    logic [SLOT_W-1:0]   recent_reg,   recent_next;
    logic                fault_reg,    fault_next;

    logic [SLOT_W-1:0]   sel;
    logic                slot_ok;
    profile_t            prof;
    logic [PULSE_W-1:0]  prof_pulse;
    logic [TICK_W-1:0]   prof_run;
    logic                allowed;
    logic [TICK_W-1:0]   elapsed_inc;
    logic [LOWRUN_W-1:0] low_run_inc;
    logic                accepted;
    logic                finished;
    logic                motor;

    // Pick the requested profile and check it against the limits, the phase, drive readiness and the fault latch
    always_comb
    begin
        sel     = slot - SLOT_W'(1);
        slot_ok = (slot != '0) && (32'(slot) <= SLOT_COUNT) && (32'(slot) <= PROFILE_REGS);
        prof    = (32'(sel) < PROFILE_REGS) ? profiles[sel] : '0;
        prof_pulse = prof[PULSE_W-1:0];
        prof_run   = prof[PULSE_W +: TICK_W];
        allowed = slot_ok && (phase_reg == PH_IDLE) && drive_ready && !fault_reg &&
                  (32'(prof_pulse) >= PULSE_MIN) && (32'(prof_pulse) <= PULSE_MAX) &&
                  (32'(prof_run) >= RUN_MIN_TICKS) && (32'(prof_run) <= RUN_MAX_TICKS);
    end

    assign elapsed_inc = elapsed_reg + TICK_W'(1);
    assign low_run_inc = (low_run_reg == '1) ? low_run_reg : low_run_reg + LOWRUN_W'(1);

    // Step the sequencer by one item
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        low_run_next = low_run_reg;
        channel_next = channel_reg;
        pulse_next   = pulse_reg;
        limit_next   = limit_reg;
        status_next  = status_reg;
        recent_next  = recent_reg;
        fault_next   = fault_reg;
        accepted     = 1'b0;
        finished     = 1'b0;

        case (mode)
            MODE_TICK:
            begin
                case (phase_reg)
                    PH_CLEAR:
                    begin
                        if (!beam_clear)
                        begin
                            phase_next  = PH_IDLE;
                            status_next = ST_BLOCKED;
                            finished    = 1'b1;
                        end
                        else if (elapsed_inc >= TICK_W'(clear_window))
                        begin
                            phase_next   = PH_RUN;
                            elapsed_next = '0;
                            low_run_next = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    PH_RUN:
                    begin
                        elapsed_next = elapsed_inc;
                        low_run_next = beam_clear ? '0 : low_run_inc;
                        if (!beam_clear && (32'(low_run_inc) >= REQUIRED_LOW_SAMPLES))
                        begin
                            phase_next  = PH_IDLE;
                            status_next = ST_DETECTED;
                            finished    = 1'b1;
                        end
                        else if (elapsed_inc >= limit_reg)
                        begin
                            phase_next  = PH_IDLE;
                            status_next = ST_TIMEOUT;
                            finished    = 1'b1;
                        end
                    end
                    PH_CAL:
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= limit_reg)
                        begin
                            phase_next  = PH_IDLE;
                            status_next = ST_CALDONE;
                            finished    = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_START, MODE_CAL:
            begin
                if (allowed)
                begin
                    channel_next = sel;
                    pulse_next   = prof_pulse;
                    limit_next   = prof_run;
                    elapsed_next = '0;
                    low_run_next = '0;
                    status_next  = ST_RUNNING;
                    accepted     = 1'b1;
                    if (mode == MODE_START)
                    begin
                        phase_next  = PH_CLEAR;
                        recent_next = slot;
                    end
                    else
                    begin
                        phase_next = PH_CAL;
                    end
                end
            end
            MODE_STOP:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next  = PH_IDLE;
                    status_next = ST_STOPPED;
                    finished    = 1'b1;
                end
            end
            MODE_FAULT:
            begin
                finished    = (phase_reg != PH_IDLE);
                phase_next  = PH_IDLE;
                fault_next  = 1'b1;
                status_next = ST_FAULT;
            end
            default:
            begin
            end
        endcase
    end

    // Form the result from the state after this item
    always_comb
    begin
        motor             = (phase_next == PH_RUN) || (phase_next == PH_CAL);
        res.accepted      = accepted;
        res.busy_res      = (phase_next != PH_IDLE);
        res.motor_on      = motor;
        res.motor_channel = channel_next;
        res.motor_pulse   = motor ? pulse_next : '0;
        res.status        = status_next;
        res.last_slot     = recent_next;
        res.finished      = finished;
    end

    // Advance the state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            low_run_reg <= '0;
            channel_reg <= '0;
            pulse_reg   <= '0;
            limit_reg   <= '0;
            status_reg  <= ST_IDLE;
            recent_reg  <= '0;
            fault_reg   <= 1'b0;
        end
        else if (en)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            low_run_reg <= low_run_next;
            channel_reg <= channel_next;
            pulse_reg   <= pulse_next;
            limit_reg   <= limit_next;
            status_reg  <= status_next;
            recent_reg  <= recent_next;
            fault_reg   <= fault_next;
        end
    end

endmodule

>>> sv/servo_dispense_sequencer.sv
// Each taken item beat has its result registered, in the skid slot while the
// result register stalls. One item per cycle is taken while item_stall is low;
// a step is one pass of compare and increment logic from state to result.
// A two-entry result buffer keeps items flowing while one result is held.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, clears the
// latched fault and loads the default profiles, window 20 and drive not ready.
module servo_dispense_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sds_pkg::PROFILE_W-1:0]      cfg_data,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [sds_pkg::MODE_W-1:0]         mode,
    input  logic [sds_pkg::SLOT_W-1:0]         slot,
    input  logic                               beam_clear,
    // result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               accepted,
    output logic                               busy_res,
    output logic                               motor_on,
    output logic [sds_pkg::CHAN_W-1:0]         motor_channel,
    output logic [sds_pkg::PULSE_W-1:0]        motor_pulse,
    output logic [sds_pkg::STATUS_W-1:0]       status,
    output logic [sds_pkg::SLOT_W-1:0]         last_slot,
    output logic                               finished
);
    import sds_pkg::*;

    profile_arr_t          profile_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic                  ready_reg;

    res_t                  step_res;
    res_t                  out_reg;
    res_t                  skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  item_take;
    logic                  out_free;

    assign cfg_ready = 1'b1;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= PROFILE_RESET;
            window_reg  <= WINDOW_RESET;
            ready_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index <= CFG_SLOT6)
            begin
                profile_reg[cfg_index] <= cfg_data;
            end
            else if (cfg_index == CFG_WINDOW)
            begin
                window_reg <= cfg_data[WINDOW_W-1:0];
            end
            else if (cfg_index == CFG_READY)
            begin
                ready_reg <= cfg_data[0];
            end
        end
    end

    // Stall items only while the spare result slot is occupied
    assign item_stall = skid_valid_reg;
    assign item_take  = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !res_stall;

    sds_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (item_take),
        .mode         (mode),
        .slot         (slot),
        .beam_clear   (beam_clear),
        .profiles     (profile_reg),
        .clear_window (window_reg),
        .drive_ready  (ready_reg),
        .res          (step_res)
    );

    // Result register and skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= item_take;
            end
        end
        else if (item_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        else if (item_take)
        begin
            skid_reg <= step_res;
        end
    end

    assign res_valid     = out_valid_reg;
    assign accepted      = out_reg.accepted;
    assign busy_res      = out_reg.busy_res;
    assign motor_on      = out_reg.motor_on;
    assign motor_channel = out_reg.motor_channel;
    assign motor_pulse   = out_reg.motor_pulse;
    assign status        = out_reg.status;
    assign last_slot     = out_reg.last_slot;
    assign finished      = out_reg.finished;

endmodule

>>> sv/sds_checker.sv
module sds_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               res_valid,
    input  logic                               res_stall,
    input  logic                               accepted,
    input  logic                               busy_res,
    input  logic                               motor_on,
    input  logic [sds_pkg::PULSE_W-1:0]        motor_pulse,
    input  logic [sds_pkg::STATUS_W-1:0]       status,
    input  logic                               finished
);
    import sds_pkg::*;

    // A beat that ends a cycle leaves the sequencer idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && finished |-> !busy_res)
        else $error("finished beat still busy");

    // The motor only turns inside a running cycle
    a_motor_running: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && motor_on |-> busy_res && (status == ST_RUNNING))
        else $error("motor on outside a running cycle");

    // A stopped motor drives no pulse
    a_pulse_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !motor_on |-> (motor_pulse == '0))
        else $error("pulse driven with motor off");

    // An accepted start opens a cycle and cannot also end one
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && accepted |-> busy_res && !finished && (status == ST_RUNNING))
        else $error("accepted start without an active cycle");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(finished))
        else $error("stalled result beat changed");

endmodule

bind servo_dispense_sequencer sds_checker u_sds_checker (.*);

>>> tb/tb_servo_dispense_sequencer.sv
module tb_servo_dispense_sequencer;
    import sds_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 16;
    localparam int REPORT_CAP    = 100;
    localparam int RUN_TICK_CAP  = 300;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_WINDOW, SEQ_DRIVE, SEQ_CALIB} seq_phase_t;

    // Block ports
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [PROFILE_W-1:0] cfg_data   = '0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic [MODE_W-1:0]    mode       = MODE_TICK;
    logic [SLOT_W-1:0]    slot       = '0;
    logic                 beam_clear = 1'b1;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    logic                 accepted;
    logic                 busy_res;
    logic                 motor_on;
    logic [CHAN_W-1:0]    motor_channel;
    logic [PULSE_W-1:0]   motor_pulse;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    last_slot;
    logic                 finished;

    // Registers as the sequencer should see them
    profile_t             slot_profile [PROFILE_REGS];
    logic [WINDOW_W-1:0]  window_ticks;
    logic                 driver_ready;

    // Sequencer state as it should stand after the last accepted beat
    seq_phase_t           seq_phase;
    logic [TICK_W-1:0]    tick_count;
    logic [LOWRUN_W-1:0]  low_count;
    logic [CHAN_W-1:0]    run_channel;
    logic [PULSE_W-1:0]   run_pulse;
    logic [TICK_W-1:0]    run_limit;
    logic [STATUS_W-1:0]  cycle_code;
    logic [SLOT_W-1:0]    dispensed_slot;
    logic                 fault_latched;

    res_t                 sequencer_reports [$];
    res_t                 seen_beat;
    res_t                 due_beat;
    int                   beat_count  = 0;
    int                   items_sent  = 0;
    int                   error_count = 0;
    bit                   no_idle     = 1'b0;

    servo_dispense_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .slot          (slot),
        .beam_clear    (beam_clear),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .accepted      (accepted),
        .busy_res      (busy_res),
        .motor_on      (motor_on),
        .motor_channel (motor_channel),
        .motor_pulse   (motor_pulse),
        .status        (status),
        .last_slot     (last_slot),
        .finished      (finished)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic profile_t profile_word(input int run, input int pulse);
        return profile_t'(((run & 'hFFF) << PULSE_W) | (pulse & 'hFFF));
    endfunction

    task automatic reset_sequencer_model();
        // power-on profiles: pulse 307 everywhere, shorter runs on slots four and six
        for (int k = 0; k < PROFILE_REGS; k++)
            slot_profile[k] = profile_word(2100, 307);
        slot_profile[3] = profile_word(1850, 307);
        slot_profile[5] = profile_word(1600, 307);
        window_ticks   = 8'd20;
        driver_ready   = 1'b0;
        seq_phase      = SEQ_IDLE;
        tick_count     = '0;
        low_count      = '0;
        run_channel    = '0;
        run_pulse      = '0;
        run_limit      = '0;
        cycle_code     = ST_IDLE;
        dispensed_slot = '0;
        fault_latched  = 1'b0;
    endtask

    function automatic bit start_ok(input logic [SLOT_W-1:0] req);
        logic [PULSE_W-1:0] pulse;
        logic [TICK_W-1:0]  run;
        if (req < 1 || req > SLOT_COUNT || req > PROFILE_REGS)
            return 1'b0;
        if (seq_phase != SEQ_IDLE || !driver_ready || fault_latched)
            return 1'b0;
        pulse = slot_profile[req - 1][PULSE_W-1:0];
        run   = slot_profile[req - 1][PROFILE_W-1:PULSE_W];
        return pulse >= PULSE_MIN && pulse <= PULSE_MAX &&
               run >= RUN_MIN_TICKS && run <= RUN_MAX_TICKS;
    endfunction

    function automatic void begin_cycle(input logic [SLOT_W-1:0] req, input seq_phase_t next);
        run_channel = req - 1'b1;
        run_pulse   = slot_profile[req - 1][PULSE_W-1:0];
        run_limit   = slot_profile[req - 1][PROFILE_W-1:PULSE_W];
        tick_count  = '0;
        low_count   = '0;
        seq_phase   = next;
        cycle_code  = ST_RUNNING;
    endfunction

    function automatic logic close_cycle(input logic [STATUS_W-1:0] code);
        seq_phase  = SEQ_IDLE;
        cycle_code = code;
        return 1'b1;
    endfunction

    // Advance the sequencer by one item and give the beat it should report
    function automatic res_t step_sequencer(input logic [MODE_W-1:0] m,
                                            input logic [SLOT_W-1:0] s, input logic b);
        res_t r;
        logic took;
        logic done;
        logic hit;
        took = 1'b0;
        done = 1'b0;
        hit  = 1'b0;
        case (m)
            MODE_TICK:
            begin
                if (seq_phase == SEQ_WINDOW)
                begin
                    if (!b)
                        done = close_cycle(ST_BLOCKED);
                    else
                    begin
                        tick_count = tick_count + 1'b1;
                        if (tick_count >= window_ticks)
                        begin
                            seq_phase  = SEQ_DRIVE;
                            tick_count = '0;
                            low_count  = '0;
                        end
                    end
                end
                else if (seq_phase == SEQ_DRIVE)
                begin
                    if (!b)
                    begin
                        if (low_count < 7)
                            low_count = low_count + 1'b1;
                        hit = (low_count >= REQUIRED_LOW_SAMPLES);
                    end
                    else
                        low_count = '0;
                    tick_count = tick_count + 1'b1;
                    // detection beats timeout on the same tick
                    if (hit)
                        done = close_cycle(ST_DETECTED);
                    else if (tick_count >= run_limit)
                        done = close_cycle(ST_TIMEOUT);
                end
                else if (seq_phase == SEQ_CALIB)
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= run_limit)
                        done = close_cycle(ST_CALDONE);
                end
            end
            MODE_START:
            begin
                if (start_ok(s))
                begin
                    begin_cycle(s, SEQ_WINDOW);
                    dispensed_slot = s;
                    took = 1'b1;
                end
            end
            MODE_CAL:
            begin
                if (start_ok(s))
                begin
                    begin_cycle(s, SEQ_CALIB);
                    took = 1'b1;
                end
            end
            MODE_STOP:
            begin
                if (seq_phase != SEQ_IDLE)
                    done = close_cycle(ST_STOPPED);
            end
            MODE_FAULT:
            begin
                done = (seq_phase != SEQ_IDLE);
                void'(close_cycle(ST_FAULT));
                fault_latched = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.accepted      = took;
        r.busy_res      = (seq_phase != SEQ_IDLE);
        r.motor_on      = (seq_phase == SEQ_DRIVE || seq_phase == SEQ_CALIB);
        r.motor_channel = run_channel;
        r.motor_pulse   = r.motor_on ? run_pulse : '0;
        r.status        = cycle_code;
        r.last_slot     = dispensed_slot;
        r.finished      = done;
        return r;
    endfunction

    task automatic report_error(input string what);
        if (error_count < REPORT_CAP)
            $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string field, input logic [PULSE_W-1:0] seen,
                                 input logic [PULSE_W-1:0] due);
        if (seen !== due)
            report_error($sformatf("beat %0d: %s is %0d, should be %0d",
                                   beat_count, field, seen, due));
    endtask

    // Offer one item beat, hold it through stalls, then predict its result
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                             input logic b);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        mode       = m;
        slot       = s;
        beam_clear = b;
        do
            @(posedge clk);
        while (item_stall);
        sequencer_reports.push_back(step_sequencer(m, s, b));
        items_sent++;
    endtask

    task automatic send_tick(input logic b);
        send_item(MODE_TICK, SLOT_W'($urandom_range(0, 7)), b);
    endtask

    // Drop valid and hold off until every expected beat is home
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (sequencer_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input profile_t data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < PROFILE_REGS)
            slot_profile[idx] = data;
        else if (idx == CFG_WINDOW)
            window_ticks = data[WINDOW_W-1:0];
        else if (idx == CFG_READY)
            driver_ready = data[0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_profiles(input int run_lo, input int run_hi, input int raw_percent);
        for (int k = 0; k < PROFILE_REGS; k++)
        begin
            if ($urandom_range(0, 99) < raw_percent)
                write_reg(CFG_SLOT1 + CFG_IDX_W'(k), PROFILE_W'($urandom));
            else
                write_reg(CFG_SLOT1 + CFG_IDX_W'(k),
                          profile_word($urandom_range(run_lo, run_hi),
                                       $urandom_range(PULSE_MIN, PULSE_MAX)));
        end
    endtask

    // Any mode but a drive fault, unused codes included
    function automatic logic [MODE_W-1:0] noise_mode();
        logic [MODE_W-1:0] m;
        m = MODE_W'($urandom_range(0, 6));
        if (m >= MODE_FAULT)
            m = m + 1'b1;
        return m;
    endfunction

    // One start or calibration item followed by ticks, with stray noise items, until
    // the cycle ends by detection, block, timeout, calibration done or stop
    task automatic play_cycle(input logic [MODE_W-1:0] kind);
        int   style;
        int   target;
        int   ticks;
        bit   blocked;
        logic prev_low;
        logic b;
        style    = $urandom_range(0, 2);
        target   = $urandom_range(0, 40);
        blocked  = ($urandom_range(0, 9) == 0);
        ticks    = 0;
        prev_low = 1'b0;
        if ($urandom_range(0, 9) == 0)
            send_item(kind, SLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        else
            send_item(kind, SLOT_W'($urandom_range(1, SLOT_COUNT)), 1'($urandom_range(0, 1)));
        while (seq_phase != SEQ_IDLE)
        begin
            if ($urandom_range(0, 99) < 3)
                send_item(noise_mode(), SLOT_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            else if ((style == 2 && ticks >= target) || ticks >= RUN_TICK_CAP)
                send_item(MODE_STOP, SLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            else
            begin
                if (seq_phase == SEQ_WINDOW)
                    b = !(blocked && $urandom_range(0, 3) == 0);
                else if (style == 0 && ticks >= target)
                    b = 1'b0;
                else
                    // keep lows isolated so they never add up to a detection
                    b = prev_low || ($urandom_range(0, 99) >= 10);
                prev_low = !b;
                send_tick(b);
                ticks++;
            end
        end
    endtask

    task automatic run_random(input int budget);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                play_cycle(MODE_START);
            else if (pick < 70)
                play_cycle(MODE_CAL);
            else
                send_item(noise_mode(), SLOT_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < 3)
                drain();
        end
        drain();
    endtask

    task automatic test_idle_items();
        // driver not ready: starts bounce, idle ticks and stops change nothing
        send_tick(1'b1);
        send_tick(1'b0);
        send_item(MODE_STOP, 3'd2, 1'b0);
        for (int u = MODE_FAULT + 1; u < 8; u++)
            send_item(MODE_W'(u), SLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        send_item(MODE_START, 3'd1, 1'b1);
        send_item(MODE_CAL, 3'd3, 1'b0);
        drain();
    endtask

    task automatic test_start_checks();
        write_reg(CFG_READY, 24'h000001);
        write_reg(CFG_SLOT1 + 3'd1, profile_word(RUN_MIN_TICKS, PULSE_MIN - 1));
        write_reg(CFG_SLOT1 + 3'd2, profile_word(RUN_MIN_TICKS, PULSE_MAX + 1));
        write_reg(CFG_SLOT1 + 3'd3, profile_word(RUN_MIN_TICKS - 1, PULSE_MIN));
        write_reg(CFG_SLOT1 + 3'd4, profile_word(RUN_MAX_TICKS + 1, PULSE_MAX));
        write_reg(CFG_SLOT1, profile_word(RUN_MIN_TICKS, PULSE_MIN));
        write_reg(CFG_SLOT6, profile_word(RUN_MAX_TICKS, PULSE_MAX));
        // slots out of range and profiles just past each limit
        send_item(MODE_START, 3'd0, 1'b1);
        send_item(MODE_CAL, 3'd7, 1'b0);
        send_item(MODE_START, 3'd2, 1'b1);
        send_item(MODE_CAL, 3'd3, 1'b1);
        send_item(MODE_START, 3'd4, 1'b0);
        send_item(MODE_CAL, 3'd5, 1'b1);
        // edge profile accepted, then a busy block turns every start away
        send_item(MODE_START, 3'd6, 1'b1);
        send_item(MODE_START, 3'd1, 1'b1);
        send_item(MODE_CAL, 3'd1, 1'b0);
        send_item(MODE_STOP, 3'd0, 1'b1);
        drain();
    endtask

    task automatic test_dispense_paths();
        // zero window behaves as one tick, then two lows detect
        write_reg(CFG_WINDOW, 24'd0);
        send_item(MODE_START, 3'd1, 1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        // interrupted beam in the window
        send_item(MODE_START, 3'd6, 1'b0);
        send_tick(1'b0);
        drain();
        // shrink the window mid-cycle: compared live on every tick
        write_reg(CFG_WINDOW, 24'd3);
        send_item(MODE_START, 3'd1, 1'b1);
        send_tick(1'b1);
        drain();
        write_reg(CFG_WINDOW, 24'd1);
        send_tick(1'b1);
        drain();
        // the running cycle keeps the profile it copied at the start
        write_reg(CFG_SLOT1, profile_word(RUN_MAX_TICKS, PULSE_MAX));
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_item(MODE_STOP, 3'd5, 1'b0);
        send_item(MODE_CAL, 3'd6, 1'b1);
        send_tick(1'b0);
        send_item(MODE_STOP, 3'd6, 1'b1);
        drain();
    endtask

    task automatic test_random_phases();
        // back-to-back beats on both sides, shortest runs so timeouts come often
        no_idle = 1'b1;
        write_reg(CFG_WINDOW, 24'd1);
        load_profiles(RUN_MIN_TICKS, RUN_MIN_TICKS + 20, 0);
        run_random(100);
        no_idle = 1'b0;
        write_reg(CFG_WINDOW, PROFILE_W'($urandom_range(2, 6)));
        load_profiles(RUN_MIN_TICKS, 400, 15);
        run_random(100);
        // longest window: only a cycle or two
        write_reg(CFG_WINDOW, 24'd255);
        run_random(20);
        // driver dropped with every upper data bit set
        write_reg(CFG_READY, 24'hFFFFFE);
        run_random(20);
        write_reg(CFG_READY, 24'h000001);
        write_reg(CFG_WINDOW, PROFILE_W'($urandom_range(0, 12)));
        load_profiles(RUN_MIN_TICKS, RUN_MAX_TICKS, 30);
        run_random(100);
    endtask

    task automatic test_fault_latch();
        write_reg(CFG_SLOT1 + 3'd1, profile_word(RUN_MIN_TICKS, PULSE_MIN));
        write_reg(CFG_WINDOW, 24'd2);
        // fault while the motor runs ends the cycle
        send_item(MODE_START, 3'd2, 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_item(MODE_FAULT, 3'd2, 1'b1);
        send_item(MODE_FAULT, 3'd0, 1'b0);
        // latched: nothing starts any more
        send_item(MODE_START, 3'd2, 1'b1);
        send_item(MODE_CAL, 3'd2, 1'b0);
        send_tick(1'b0);
        send_item(MODE_STOP, 3'd2, 1'b1);
        repeat (40)
            send_item(MODE_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
        drain();
    endtask

    // Receiver stalls at random unless the no-idle stretch is on
    always @(negedge clk)
    begin
        res_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Check every result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            seen_beat = {accepted, busy_res, motor_on, motor_channel, motor_pulse,
                         status, last_slot, finished};
            if (sequencer_reports.size() == 0)
                report_error($sformatf("beat %0d arrived with nothing predicted", beat_count));
            else
            begin
                due_beat = sequencer_reports.pop_front();
                compare_field("accepted", PULSE_W'(seen_beat.accepted),
                              PULSE_W'(due_beat.accepted));
                compare_field("busy_res", PULSE_W'(seen_beat.busy_res),
                              PULSE_W'(due_beat.busy_res));
                compare_field("motor_on", PULSE_W'(seen_beat.motor_on),
                              PULSE_W'(due_beat.motor_on));
                compare_field("motor_channel", PULSE_W'(seen_beat.motor_channel),
                              PULSE_W'(due_beat.motor_channel));
                compare_field("motor_pulse", seen_beat.motor_pulse, due_beat.motor_pulse);
                compare_field("status", PULSE_W'(seen_beat.status),
                              PULSE_W'(due_beat.status));
                compare_field("last_slot", PULSE_W'(seen_beat.last_slot),
                              PULSE_W'(due_beat.last_slot));
                compare_field("finished", PULSE_W'(seen_beat.finished),
                              PULSE_W'(due_beat.finished));
            end
            beat_count++;
        end
    end

    // Abort when no beat moves on any channel for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_servo_dispense_sequencer failed");
        $finish;
    end

    initial
    begin
        reset_sequencer_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_idle_items();
        test_start_checks();
        test_dispense_paths();
        test_random_phases();
        test_fault_latch();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sequencer_reports.size() != 0)
            report_error($sformatf("%0d predicted beats never arrived",
                                   sequencer_reports.size()));
        if (error_count == 0)
            $display("tb_servo_dispense_sequencer passed");
        else
            $display("tb_servo_dispense_sequencer failed");
        $finish;
    end

endmodule

>>> servo_dispense_sequencer.f
sv/sds_pkg.sv
sv/sds_core.sv
sv/servo_dispense_sequencer.sv
sv/sds_checker.sv
tb/tb_servo_dispense_sequencer.sv
